[sv/srfp_pkg.sv]
// Package for the serial report frame parser.
// Holds the configuration and result structs, event and register codes, and widths.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package srfp_pkg;

  // Number of payload bytes that are kept for dispatch by default.
  localparam int unsigned KEPT_PAYLOAD_DEF = 4;

  // Smallest legal total frame length: two markers, length, type, end mark.
  localparam logic [7:0] MIN_FRAME_LEN = 8'd5;

  // Configuration port address width: six registers at byte addresses 4*i.
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  // Packed stream widths.
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 48;
  localparam int unsigned M_TUSER_W = 2;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_TRACK = 2'd1,
    EV_HELLO = 2'd2,
    EV_ERROR = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    REG_START1    = 3'd0,
    REG_START2    = 3'd1,
    REG_END       = 3'd2,
    REG_MAX_LEN   = 3'd3,
    REG_TRACK_RPT = 3'd4,
    REG_HELLO     = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] start_byte_one;
    logic [7:0] start_byte_two;
    logic [7:0] end_byte;
    logic [7:0] max_frame_length;
    logic [7:0] track_report_code;
    logic [7:0] hello_code;
  } cfg_t;

  typedef struct packed {
    event_e      event_res;
    logic [15:0] track_number;
    logic        track_playing;
    logic [7:0]  voice_count;
    logic [15:0] track_total;
    logic        hello_seen;
  } res_t;

endpackage

[sv/serial_report_frame_parser.sv]
// Top level of the serial report frame parser: stream ports, input and result registers.
// Depends on srfp_pkg, srfp_cfg_regs and srfp_deframer.
//
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+-------------------------------------
// s_axis    | in        | tvalid / tready        | tdata[7:0] rx_byte
// m_axis    | out       | tvalid / tready        | tdata status fields, tuser event_res
// apb       | in        | psel, penable, pready  | paddr, pwdata, prdata (six registers)
//
// Each received byte is one item and produces exactly one result item. An accepted item
// is held in the input register, is processed by the deframer logic and lands in the
// result register, from which it is presented on m_axis. One item per cycle is sustained
// while m_axis_tready stays high. Reset clears the frame state and the reported status to
// zero and loads the register defaults. When the result side stalls, the input register
// holds its item and s_axis_tready drops only once both registers are full.
`timescale 1ns / 1ps

module serial_report_frame_parser #(
  parameter int unsigned KEPT_PAYLOAD = srfp_pkg::KEPT_PAYLOAD_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Received byte stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [srfp_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [7:0] rx_byte
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] track_number, [16] track_playing, [24:17] voice_count,
  // [40:25] track_total, [41] hello_seen, [47:42] zero
  output logic [srfp_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  output logic [srfp_pkg::M_TUSER_W-1:0]   m_axis_tuser,   // [1:0] event_res
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [srfp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [srfp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [srfp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import srfp_pkg::*;

  cfg_t       cfg;
  res_t       res;
  res_t       res_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  logic       advance;

  srfp_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The held byte moves on whenever the result register is empty or being drained.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  srfp_deframer #(
    .KEPT_PAYLOAD (KEPT_PAYLOAD)
  ) u_deframer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_i    (advance),
    .rx_byte_i (in_byte_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.event_res;
  assign m_axis_tdata  = {6'd0, res_q.hello_seen, res_q.track_total, res_q.voice_count,
                          res_q.track_playing, res_q.track_number};

endmodule

[sv/srfp_cfg_regs.sv]
// Configuration register bank of the serial report frame parser, on an APB-style port.
// Depends on srfp_pkg for the register codes, widths and the cfg_t struct.
`timescale 1ns / 1ps

module srfp_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [srfp_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [srfp_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [srfp_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output srfp_pkg::cfg_t                     cfg_o
);
  import srfp_pkg::*;

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[4:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_START1:    cfg_d.start_byte_one    = pwdata[7:0];
        REG_START2:    cfg_d.start_byte_two    = pwdata[7:0];
        REG_END:       cfg_d.end_byte          = pwdata[7:0];
        REG_MAX_LEN:   cfg_d.max_frame_length  = pwdata[7:0];
        REG_TRACK_RPT: cfg_d.track_report_code = pwdata[7:0];
        REG_HELLO:     cfg_d.hello_code        = pwdata[7:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_START1:    prdata = {24'd0, cfg_q.start_byte_one};
      REG_START2:    prdata = {24'd0, cfg_q.start_byte_two};
      REG_END:       prdata = {24'd0, cfg_q.end_byte};
      REG_MAX_LEN:   prdata = {24'd0, cfg_q.max_frame_length};
      REG_TRACK_RPT: prdata = {24'd0, cfg_q.track_report_code};
      REG_HELLO:     prdata = {24'd0, cfg_q.hello_code};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte_one    <= 8'd240;
      cfg_q.start_byte_two    <= 8'd170;
      cfg_q.end_byte          <= 8'd85;
      cfg_q.max_frame_length  <= 8'd32;
      cfg_q.track_report_code <= 8'd141;
      cfg_q.hello_code        <= 8'd228;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/srfp_deframer.sv]
// Frame state, payload store and message dispatch of the serial report frame parser.
// Depends on srfp_pkg for cfg_t, res_t, event codes and the minimum frame length.
`timescale 1ns / 1ps

module srfp_deframer #(
  parameter int unsigned KEPT_PAYLOAD = srfp_pkg::KEPT_PAYLOAD_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  srfp_pkg::cfg_t cfg_i,
  input  logic           step_i,
  input  logic [7:0]     rx_byte_i,
  output srfp_pkg::res_t res_o
);
  import srfp_pkg::*;

  localparam int unsigned IdxW = $clog2(KEPT_PAYLOAD);
  localparam logic [7:0] PosIdle    = 8'd0;
  localparam logic [7:0] PosStart2  = 8'd1;
  localparam logic [7:0] PosLength  = 8'd2;
  localparam logic [7:0] PosPayload = 8'd3;
  localparam logic [7:0] KeptBytes  = 8'(KEPT_PAYLOAD);

  logic [7:0]  pos_q, pos_d;
  logic [7:0]  end_pos_q, end_pos_d;
  logic [7:0]  store_q [KEPT_PAYLOAD];
  logic [15:0] track_q, track_d;
  logic        playing_q, playing_d;
  logic [7:0]  voices_q, voices_d;
  logic [15:0] tracks_q, tracks_d;
  logic        hello_q, hello_d;

  logic        is_marker;
  logic [7:0]  slot;
  logic        store_wr;
  event_e      ev;

  assign is_marker = (rx_byte_i == cfg_i.start_byte_one) ||
                     (rx_byte_i == cfg_i.start_byte_two) ||
                     (rx_byte_i == cfg_i.end_byte);
  assign slot = pos_q - PosPayload;

  always_comb begin
    pos_d     = pos_q;
    end_pos_d = end_pos_q;
    track_d   = track_q;
    playing_d = playing_q;
    voices_d  = voices_q;
    tracks_d  = tracks_q;
    hello_d   = hello_q;
    store_wr  = 1'b0;
    ev        = EV_NONE;
    priority if (pos_q == PosIdle) begin
      if (rx_byte_i == cfg_i.start_byte_one) begin
        pos_d = PosStart2;
      end
    end else if (pos_q == PosStart2) begin
      if (rx_byte_i != cfg_i.start_byte_two) begin
        ev        = EV_ERROR;
        pos_d     = PosIdle;
        end_pos_d = '0;
      end else begin
        pos_d = PosLength;
      end
    end else if (pos_q == PosLength) begin
      if (is_marker || (rx_byte_i < MIN_FRAME_LEN) ||
          (rx_byte_i > cfg_i.max_frame_length)) begin
        ev        = EV_ERROR;
        pos_d     = PosIdle;
        end_pos_d = '0;
      end else begin
        end_pos_d = rx_byte_i - 8'd1;
        pos_d     = PosPayload;
      end
    end else if (pos_q < end_pos_q) begin
      if (is_marker) begin
        ev        = EV_ERROR;
        pos_d     = PosIdle;
        end_pos_d = '0;
      end else begin
        store_wr = (slot < KeptBytes);
        pos_d    = pos_q + 8'd1;
      end
    end else if ((pos_q == end_pos_q) && (rx_byte_i == cfg_i.end_byte)) begin
      pos_d     = PosIdle;
      end_pos_d = '0;
      // The message type in the first payload byte selects the update;
      // a track report wins when both codes are equal.
      priority if (store_q[0] == cfg_i.track_report_code) begin
        ev        = EV_TRACK;
        track_d   = {store_q[2], store_q[1]};
        playing_d = (store_q[3] != 8'd0);
      end else if (store_q[0] == cfg_i.hello_code) begin
        ev       = EV_HELLO;
        voices_d = store_q[1];
        tracks_d = {store_q[3], store_q[2]};
        hello_d  = 1'b1;
      end else begin
        ev = EV_NONE;
      end
    end else begin
      ev        = EV_ERROR;
      pos_d     = PosIdle;
      end_pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      end_pos_q <= '0;
      track_q   <= '0;
      playing_q <= 1'b0;
      voices_q  <= '0;
      tracks_q  <= '0;
      hello_q   <= 1'b0;
    end else if (step_i) begin
      pos_q     <= pos_d;
      end_pos_q <= end_pos_d;
      track_q   <= track_d;
      playing_q <= playing_d;
      voices_q  <= voices_d;
      tracks_q  <= tracks_d;
      hello_q   <= hello_d;
    end
  end

  // Payload bytes have no reset; a short frame can leave entries read at dispatch unwritten or stale.
  always_ff @(posedge clk_i) begin
    if (step_i && store_wr) begin
      store_q[slot[IdxW-1:0]] <= rx_byte_i;
    end
  end

  assign res_o.event_res     = ev;
  assign res_o.track_number  = track_d;
  assign res_o.track_playing = playing_d;
  assign res_o.voice_count   = voices_d;
  assign res_o.track_total   = tracks_d;
  assign res_o.hello_seen    = hello_d;

endmodule
